// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the Life generation engine.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TLGE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlge: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TLGE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlge: next-cycle check failed");

`endif

// ----- rtl/tlge_pkg.sv -----
// Shared types and constants for the toroidal Life generation engine.
// No dependencies; imported by the engine top level and its row unit.
`default_nettype none

package tlge_pkg;

  // Fixed field widths of the command and response words.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int GRID_W  = 7;
  localparam int COUNT_W = 13;

  // Default grid capacity and the reset value of the size register.
  localparam int MAX_SIZE_DEFAULT = 64;
  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  // Neighbor counts of the Life rule.
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_in;
  } cmd_word_t;

  typedef struct packed {
    logic               cell_out;
    logic [COUNT_W-1:0] live_count;
    logic               range_error;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WB,
    ST_STEP,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/toroidal_life_generation_engine.sv -----
// A cell write or read passes through a RAM read state, a write-back state and a result state.
// An out-of-range address, an unused command or a step at size zero goes straight to the result state.
// A step reads one row per cycle from one RAM port and writes each new row to the other bank.
// Throughput: one command at a time; the next is accepted the cycle after its response is
// registered, and a stalled response word holds the next result and the input back.
// Reset sets the size to 64, makes bank A current and zeroes both banks through row valid bits.
`default_nettype none
`include "assert_macros.svh"

module toroidal_life_generation_engine #(
  parameter int MAX_SIZE = tlge_pkg::MAX_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  tlge_pkg::cmd_word_t           cmd_word,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output tlge_pkg::rsp_word_t           rsp_word,
  input  logic                          cfg_wr_en,
  input  logic [tlge_pkg::GRID_W-1:0]   cfg_wr_data
);
  import tlge_pkg::*;

  localparam int ROW_W  = $clog2(MAX_SIZE);
  localparam int ROWS   = 1 << ROW_W;
  localparam int ADDR_W = ROW_W + 1;
  localparam int N_W    = $clog2(MAX_SIZE+1);
  localparam int CMP_W  = (N_W > GRID_W) ? N_W : GRID_W;
  localparam int SEQ_W  = $clog2(MAX_SIZE+4);
  localparam int CNT_W  = $clog2(MAX_SIZE*MAX_SIZE+1);
  localparam int PC_W   = ROW_W + 1;

  state_t               state, state_next;
  logic [GRID_W-1:0]    grid_size;
  logic                 active;
  logic [ROWS-1:0]      vld [2];
  cmd_word_t            cmd_q;
  logic [SEQ_W-1:0]     seq;
  logic [MAX_SIZE-1:0]  prev1, prev2, nrow_q;
  logic                 nrow_vld;
  logic [CNT_W-1:0]     acc;
  logic                 res_cell, res_err;
  logic                 rd_vld_q;

  logic [CMP_W-1:0]     n_ext;
  logic [N_W-1:0]       n;
  logic [SEQ_W-1:0]     n_s;
  logic                 accept, oor;
  logic [ROW_W-1:0]     col_idx, rd_row;
  logic [MAX_SIZE-1:0]  ram_q, rd_data, patched, nrow_c;
  logic                 ram_re, ram_we, rsp_load;
  logic [ADDR_W-1:0]    ram_raddr, ram_waddr;
  logic [MAX_SIZE-1:0]  ram_wdata;
  logic [ROWS-1:0]      pc_in;
  logic [PC_W-1:0]      pc_tree [ROW_W+1][ROWS];
  logic [PC_W-1:0]      pc;

  // Size in use, clamped to the grid capacity.
  always_comb begin
    n_ext = (CMP_W'(grid_size) > CMP_W'(MAX_SIZE)) ? CMP_W'(MAX_SIZE) : CMP_W'(grid_size);
  end
  assign n   = N_W'(n_ext);
  assign n_s = SEQ_W'(n);

  // Input handshake and address range check on the incoming word.
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign oor       = (CMP_W'(cmd_word.row) >= n_ext) || (CMP_W'(cmd_word.col) >= n_ext);

  // A row never written since reset or since its bank was cleared reads as zero.
  assign rd_data = rd_vld_q ? ram_q : '0;
  assign col_idx = ROW_W'(cmd_q.col);

  // Read-modify-write row for a cell write.
  always_comb begin
    patched          = rd_data;
    patched[col_idx] = cmd_q.cell_in;
  end

  // Row read order for a step: last row, rows 0 to n-1, then row 0 again.
  always_comb begin
    if (seq == '0) begin
      rd_row = ROW_W'(n - N_W'(1));
    end else if ((seq - SEQ_W'(1)) < n_s) begin
      rd_row = ROW_W'(seq - SEQ_W'(1));
    end else begin
      rd_row = '0;
    end
  end

  // Both banks share one RAM; the top address bit selects the bank.
  tlge_ram #(
    .WIDTH (MAX_SIZE),
    .DEPTH (2*ROWS)
  ) u_bank_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Rule for the row whose lower neighbor arrives this cycle.
  tlge_row_unit #(
    .MAX_SIZE (MAX_SIZE)
  ) u_row_unit (
    .up   (prev2),
    .mid  (prev1),
    .dn   (rd_data),
    .size (n),
    .nrow (nrow_c)
  );

  // Sequencer: next state and RAM control.
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    rsp_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_word.cmd)
            CMD_WRITE, CMD_READ: state_next = oor ? ST_RESULT : ST_CELL_RD;
            CMD_STEP:            state_next = (n == '0) ? ST_RESULT : ST_STEP;
            default:             state_next = ST_RESULT;
          endcase
        end
      end
      ST_CELL_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = {active, ROW_W'(cmd_q.row)};
        state_next = ST_CELL_WB;
      end
      ST_CELL_WB: begin
        if (cmd_q.cmd == CMD_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = {active, ROW_W'(cmd_q.row)};
          ram_wdata = patched;
        end
        state_next = ST_RESULT;
      end
      ST_STEP: begin
        if (seq <= n_s + SEQ_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = {active, rd_row};
        end
        if ((seq >= SEQ_W'(3)) && (seq <= n_s + SEQ_W'(2))) begin
          ram_we    = 1'b1;
          ram_waddr = {~active, ROW_W'(seq - SEQ_W'(3))};
          ram_wdata = nrow_c;
        end
        if (seq == n_s + SEQ_W'(3)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: size, bank select, row valid bits, step counter, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
      active    <= 1'b0;
      vld[0]    <= '0;
      vld[1]    <= '0;
      seq       <= '0;
      nrow_vld  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_size <= cfg_wr_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept && (cmd_word.cmd == CMD_STEP)) begin
        vld[~active] <= '0;
        if (n == '0) begin
          active <= ~active;
        end
      end
      if (ram_we) begin
        vld[ram_waddr[ROW_W]][ram_waddr[ROW_W-1:0]] <= 1'b1;
      end
      if (accept) begin
        seq <= '0;
      end else if (state == ST_STEP) begin
        seq <= seq + SEQ_W'(1);
      end
      if ((state == ST_STEP) && (state_next == ST_RESULT)) begin
        active <= ~active;
      end
      nrow_vld <= ram_we && (state == ST_STEP);
    end
  end

  // Population count of the last new row, as a tree of pairwise adds.
  assign pc_in = ROWS'(nrow_q);
  always_comb begin
    for (int l = 0; l <= ROW_W; l++) begin
      for (int i = 0; i < ROWS; i++) begin
        pc_tree[l][i] = '0;
      end
    end
    for (int i = 0; i < ROWS; i++) begin
      pc_tree[0][i] = PC_W'(pc_in[i]);
    end
    for (int l = 0; l < ROW_W; l++) begin
      for (int i = 0; i < ROWS/2; i++) begin
        if (i < (ROWS >> (l+1))) begin
          pc_tree[l+1][i] = pc_tree[l][2*i] + pc_tree[l][2*i+1];
        end
      end
    end
  end
  assign pc = pc_tree[ROW_W][0];

  // Datapath registers: latched command, row window, count and result fields.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld_q <= vld[ram_raddr[ROW_W]][ram_raddr[ROW_W-1:0]];
    end
    if (accept) begin
      cmd_q    <= cmd_word;
      res_cell <= 1'b0;
      res_err  <= ((cmd_word.cmd == CMD_WRITE) || (cmd_word.cmd == CMD_READ)) && oor;
      acc      <= '0;
    end else begin
      if ((state == ST_CELL_WB) && (cmd_q.cmd == CMD_READ)) begin
        res_cell <= rd_data[col_idx];
      end
      if (nrow_vld) begin
        acc <= acc + CNT_W'(pc);
      end
    end
    // Sliding window of three rows over the current bank.
    if ((state == ST_STEP) && (seq >= SEQ_W'(1)) && (seq <= n_s + SEQ_W'(2))) begin
      prev2 <= prev1;
      prev1 <= rd_data;
    end
    nrow_q <= nrow_c;
    if (rsp_load) begin
      rsp_word.cell_out    <= res_cell;
      rsp_word.live_count  <= COUNT_W'(acc);
      rsp_word.range_error <= res_err;
    end
  end

  // Checks on the sequencer and the bank handling.
  `TLGE_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `TLGE_ASSERT_IMPL(a_step_writes_other_bank, clk, rst, ram_we && (state == ST_STEP), ram_waddr[ROW_W] != active)
  `TLGE_ASSERT_NEXT(a_result_issued, clk, rst, (state == ST_RESULT) && !(rsp_valid && rsp_stall), rsp_valid && (state == ST_IDLE))
  `TLGE_ASSERT_IMPL(a_count_bound, clk, rst, state == ST_RESULT, acc <= CNT_W'(MAX_SIZE*MAX_SIZE))

endmodule

`default_nettype wire

// ----- rtl/tlge_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds both grid banks of the Life engine.
`default_nettype none

module tlge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tlge_row_unit.sv -----
// Next-generation logic for one grid row, one lane per cell, with column wrap.
// Depends on tlge_pkg for the rule constants.
`default_nettype none

module tlge_row_unit #(
  parameter int MAX_SIZE = tlge_pkg::MAX_SIZE_DEFAULT
) (
  input  logic [MAX_SIZE-1:0]            up,
  input  logic [MAX_SIZE-1:0]            mid,
  input  logic [MAX_SIZE-1:0]            dn,
  input  logic [$clog2(MAX_SIZE+1)-1:0]  size,
  output logic [MAX_SIZE-1:0]            nrow
);
  import tlge_pkg::*;

  localparam int ROW_W = $clog2(MAX_SIZE);
  localparam int N_W   = $clog2(MAX_SIZE+1);

  logic [ROW_W-1:0] last_idx;

  // Column of the wrap point; unused when the size is zero.
  assign last_idx = ROW_W'(size - N_W'(1));

  for (genvar c = 0; c < MAX_SIZE; c++) begin : g_cell
    logic       ul, ur, ml, mr, dl, dr;
    logic [3:0] k;

    // Left neighbors wrap to the last column in use.
    if (c == 0) begin : g_left_wrap
      assign ul = up[last_idx];
      assign ml = mid[last_idx];
      assign dl = dn[last_idx];
    end else begin : g_left
      assign ul = up[c-1];
      assign ml = mid[c-1];
      assign dl = dn[c-1];
    end

    // Right neighbors wrap to column zero past the last column in use.
    if (c == MAX_SIZE-1) begin : g_right_wrap
      assign ur = up[0];
      assign mr = mid[0];
      assign dr = dn[0];
    end else begin : g_right
      assign ur = (N_W'(c+1) < size) ? up[c+1]  : up[0];
      assign mr = (N_W'(c+1) < size) ? mid[c+1] : mid[0];
      assign dr = (N_W'(c+1) < size) ? dn[c+1]  : dn[0];
    end

    // Live neighbor count and the Life rule; cells past the size stay dead.
    assign k = 4'(ul) + 4'(up[c]) + 4'(ur) + 4'(ml) + 4'(mr)
             + 4'(dl) + 4'(dn[c]) + 4'(dr);
    assign nrow[c] = (N_W'(c) < size)
                   && ((k == 4'(BIRTH_COUNT)) || (mid[c] && (k == 4'(SURVIVE_COUNT))));
  end

endmodule

`default_nettype wire
